### hw/rtl/assert_macros.svh
// assertion macros shared by the annular mask rotate/shift rtl
// expects clk and arst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising clock edge outside reset
`define AMRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AMRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define AMRS_ASSERT(lbl, prop, msg)
`define AMRS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hw/rtl/amrs_pkg.sv
// shared types and constants for the annular mask rotate/shift pixel core
// no dependencies
package amrs_pkg;

	localparam int IMAGE_SIZE_DEF = 256;

	localparam int PIX_W       = 8;
	localparam int RAD_W       = 20;
	localparam int EDGE_W      = 12;
	localparam int TRIG_W      = 18;
	localparam int SHIFT_W     = 18;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;

	// fraction bits of the shift and trig registers
	localparam int SHIFT_FRAC  = 8;
	localparam int TRIG_FRAC   = 16;

	// width of pixel*2^8 - shift + 1/2, signed
	localparam int SHIFT_SUM_W = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INNER     = 3'd0,
		CFG_OUTER     = 3'd1,
		CFG_EDGE      = 3'd2,
		CFG_COS       = 3'd3,
		CFG_SIN       = 3'd4,
		CFG_ROW_SHIFT = 3'd5,
		CFG_COL_SHIFT = 3'd6,
		CFG_CENTER    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic        [RAD_W-1:0]   inner_radius_sq;
		logic        [RAD_W-1:0]   outer_radius_sq;
		logic signed [EDGE_W-1:0]  edge_threshold;
		logic signed [TRIG_W-1:0]  cos_angle;
		logic signed [TRIG_W-1:0]  sin_angle;
		logic signed [SHIFT_W-1:0] row_shift;
		logic signed [SHIFT_W-1:0] col_shift;
		logic                      centering_even;
	} cfg_t;

	localparam logic        [RAD_W-1:0]   INNER_RST  = 20'd0;
	localparam logic        [RAD_W-1:0]   OUTER_RST  = 20'hFFFFF;
	localparam logic signed [EDGE_W-1:0]  EDGE_RST   = -12'sd1024;
	localparam logic signed [TRIG_W-1:0]  COS_RST    = 18'sd65536;
	localparam logic signed [TRIG_W-1:0]  SIN_RST    = 18'sd0;
	localparam logic signed [SHIFT_W-1:0] SHIFT_RST  = 18'sd0;
	localparam logic                      CENTER_RST = 1'b1;

endpackage

### hw/rtl/amrs_cfg_regs.sv
// configuration register file for the annular mask rotate/shift core
// depends on amrs_pkg and assert_macros.svh
`include "assert_macros.svh"

module amrs_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [amrs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [amrs_pkg::CFG_DATA_W-1:0]      cfg_data,
	output amrs_pkg::cfg_t                       cfg
);

	amrs_pkg::cfg_t   cfg_q;
	amrs_pkg::cfg_reg_t reg_sel;

	assign cfg_ready = 1'b1;
	assign reg_sel   = amrs_pkg::cfg_reg_t'(cfg_index);
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inner_radius_sq <= amrs_pkg::INNER_RST;
			cfg_q.outer_radius_sq <= amrs_pkg::OUTER_RST;
			cfg_q.edge_threshold  <= amrs_pkg::EDGE_RST;
			cfg_q.cos_angle       <= amrs_pkg::COS_RST;
			cfg_q.sin_angle       <= amrs_pkg::SIN_RST;
			cfg_q.row_shift       <= amrs_pkg::SHIFT_RST;
			cfg_q.col_shift       <= amrs_pkg::SHIFT_RST;
			cfg_q.centering_even  <= amrs_pkg::CENTER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_sel)
				amrs_pkg::CFG_INNER:
					cfg_q.inner_radius_sq <= cfg_data[amrs_pkg::RAD_W-1:0];
				amrs_pkg::CFG_OUTER:
					cfg_q.outer_radius_sq <= cfg_data[amrs_pkg::RAD_W-1:0];
				amrs_pkg::CFG_EDGE:
					cfg_q.edge_threshold  <= $signed(cfg_data[amrs_pkg::EDGE_W-1:0]);
				amrs_pkg::CFG_COS:
					cfg_q.cos_angle       <= $signed(cfg_data[amrs_pkg::TRIG_W-1:0]);
				amrs_pkg::CFG_SIN:
					cfg_q.sin_angle       <= $signed(cfg_data[amrs_pkg::TRIG_W-1:0]);
				amrs_pkg::CFG_ROW_SHIFT:
					cfg_q.row_shift       <= $signed(cfg_data[amrs_pkg::SHIFT_W-1:0]);
				amrs_pkg::CFG_COL_SHIFT:
					cfg_q.col_shift       <= $signed(cfg_data[amrs_pkg::SHIFT_W-1:0]);
				amrs_pkg::CFG_CENTER:
					cfg_q.centering_even  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	`AMRS_ASSERT_NEXT(a_cos_write, cfg_valid && cfg_ready && cfg_index == amrs_pkg::CFG_COS, cfg_q.cos_angle == $signed($past(cfg_data[amrs_pkg::TRIG_W-1:0])), "cos register did not take the written beat")

endmodule

### hw/rtl/amrs_shift_rot.sv
// stages 1-3: inverse shift with rounding, rotation products, rotation sum and floor
// depends on amrs_pkg and assert_macros.svh
`include "assert_macros.svh"

module amrs_shift_rot #(
	parameter int IMAGE_SIZE = amrs_pkg::IMAGE_SIZE_DEF,
	localparam int CW = $clog2(IMAGE_SIZE)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  amrs_pkg::cfg_t              cfg,
	input  logic                        up_valid,
	output logic                        up_ready,
	input  logic [amrs_pkg::PIX_W-1:0]  pixel_row,
	input  logic [amrs_pkg::PIX_W-1:0]  pixel_col,
	output logic                        dn_valid,
	input  logic                        dn_ready,
	output logic                        dn_ok,
	output logic [CW-1:0]               dn_row,
	output logic [CW-1:0]               dn_col
);

	localparam int SSW  = amrs_pkg::SHIFT_SUM_W;
	localparam int SFW  = SSW - amrs_pkg::SHIFT_FRAC;
	localparam int SHALF = 1 << (amrs_pkg::SHIFT_FRAC - 1);
	localparam int OW   = CW + 2;
	localparam int PW   = amrs_pkg::TRIG_W + OW;
	localparam int AW   = PW + 2;
	localparam int RSH  = amrs_pkg::TRIG_FRAC + 1;
	localparam int RW   = AW - RSH;
	// centre plus one half, in units of 2^-17 pixel
	localparam int BASE = IMAGE_SIZE << amrs_pkg::TRIG_FRAC;

	// stage 1: shifted source pixel
	logic                 v_s1, ok_s1;
	logic [CW-1:0]        row_src_s1, col_src_s1;
	// stage 2: rotation products
	logic                 v_s2, ok_s2;
	logic signed [PW-1:0] p_cos_row_s2, p_sin_col_s2, p_sin_row_s2, p_cos_col_s2;
	// stage 3: rotated source pixel
	logic                 v_s3, ok_s3;
	logic [CW-1:0]        row_rot_s3, col_rot_s3;

	logic rdy_s1, rdy_s2, rdy_s3;

	logic signed [SSW-1:0] row_sum, col_sum;
	logic signed [SFW-1:0] row_fl, col_fl;
	logic                  pix_in, src_in;
	logic signed [OW-1:0]  o_row, o_col;
	logic signed [AW-1:0]  a_row, a_col;
	logic signed [RW-1:0]  rr, rc;
	logic                  rot_in;

	assign rdy_s3   = !v_s3 || dn_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	// floor(p - shift + 1/2) with 8 fraction bits
	always_comb begin
		row_sum = $signed({{(SSW - amrs_pkg::PIX_W - amrs_pkg::SHIFT_FRAC){1'b0}},
			pixel_row, {amrs_pkg::SHIFT_FRAC{1'b0}}})
			- SSW'(cfg.row_shift) + SSW'(SHALF);
		col_sum = $signed({{(SSW - amrs_pkg::PIX_W - amrs_pkg::SHIFT_FRAC){1'b0}},
			pixel_col, {amrs_pkg::SHIFT_FRAC{1'b0}}})
			- SSW'(cfg.col_shift) + SSW'(SHALF);
		row_fl  = row_sum[SSW-1:amrs_pkg::SHIFT_FRAC];
		col_fl  = col_sum[SSW-1:amrs_pkg::SHIFT_FRAC];
		pix_in  = (32'(pixel_row) < IMAGE_SIZE) && (32'(pixel_col) < IMAGE_SIZE);
		src_in  = !row_fl[SFW-1] && (row_fl < SFW'(IMAGE_SIZE))
			&& !col_fl[SFW-1] && (col_fl < SFW'(IMAGE_SIZE));
	end

	// doubled offsets from the rotation centre
	always_comb begin
		o_row = $signed({1'b0, row_src_s1, 1'b0}) - OW'(IMAGE_SIZE - 1);
		o_col = $signed({1'b0, col_src_s1, 1'b0}) - OW'(IMAGE_SIZE - 1);
	end

	always_comb begin
		a_row  = AW'(p_cos_row_s2) + AW'(p_sin_col_s2) + AW'(BASE);
		a_col  = AW'(p_cos_col_s2) - AW'(p_sin_row_s2) + AW'(BASE);
		rr     = a_row[AW-1:RSH];
		rc     = a_col[AW-1:RSH];
		rot_in = !rr[RW-1] && (rr < RW'(IMAGE_SIZE))
			&& !rc[RW-1] && (rc < RW'(IMAGE_SIZE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			ok_s1      <= pix_in && src_in;
			row_src_s1 <= row_fl[CW-1:0];
			col_src_s1 <= col_fl[CW-1:0];
		end
		if (rdy_s2 && v_s1) begin
			ok_s2        <= ok_s1;
			p_cos_row_s2 <= PW'(cfg.cos_angle) * PW'(o_row);
			p_sin_col_s2 <= PW'(cfg.sin_angle) * PW'(o_col);
			p_sin_row_s2 <= PW'(cfg.sin_angle) * PW'(o_row);
			p_cos_col_s2 <= PW'(cfg.cos_angle) * PW'(o_col);
		end
		if (rdy_s3 && v_s2) begin
			ok_s3      <= ok_s2 && rot_in;
			row_rot_s3 <= rr[CW-1:0];
			col_rot_s3 <= rc[CW-1:0];
		end
	end

	assign dn_valid = v_s3;
	assign dn_ok    = ok_s3;
	assign dn_row   = row_rot_s3;
	assign dn_col   = col_rot_s3;

	`AMRS_ASSERT_NEXT(a_s1_hold, v_s1 && !rdy_s2, v_s1 && $stable(row_src_s1) && $stable(ok_s1), "stage 1 beat changed while blocked")
	`AMRS_ASSERT_NEXT(a_s1_moves, v_s1 && rdy_s2, v_s2, "stage 1 beat lost on its way to stage 2")

endmodule

### hw/rtl/amrs_annulus.sv
// stages 4-5: half-pixel coordinates, squares, annulus and edge test
// depends on amrs_pkg and assert_macros.svh
`include "assert_macros.svh"

module amrs_annulus #(
	parameter int IMAGE_SIZE = amrs_pkg::IMAGE_SIZE_DEF,
	localparam int CW = $clog2(IMAGE_SIZE)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  amrs_pkg::cfg_t cfg,
	input  logic           up_valid,
	output logic           up_ready,
	input  logic           up_ok,
	input  logic [CW-1:0]  up_row,
	input  logic [CW-1:0]  up_col,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           mask_bit
);

	localparam int XW   = CW + 2;
	localparam int QW   = 2 * CW + 1;
	localparam int EW   = (XW > amrs_pkg::EDGE_W) ? XW : amrs_pkg::EDGE_W;
	localparam int SUMW = QW + 1;
	localparam int CMPW = (SUMW > amrs_pkg::RAD_W) ? SUMW : amrs_pkg::RAD_W;

	logic                 v_s4, ok_s4;
	logic [QW-1:0]        sq_x_s4, sq_y_s4;
	logic                 v_s5, mask_s5;
	logic                 rdy_s4, rdy_s5;

	logic signed [XW-1:0]   x2, y2;
	logic signed [2*XW-1:0] x2_sq, y2_sq;
	logic                   edge_ok;
	logic [CMPW-1:0]        rad_sq;
	logic                   ring_ok;

	assign rdy_s5   = !v_s5 || !out_stall;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign up_ready = rdy_s4;

	// doubled coordinates: 2*c - n + centering
	always_comb begin
		x2      = $signed({1'b0, up_col, 1'b0}) - XW'(IMAGE_SIZE)
			+ $signed({{(XW-1){1'b0}}, cfg.centering_even});
		y2      = $signed({1'b0, up_row, 1'b0}) - XW'(IMAGE_SIZE)
			+ $signed({{(XW-1){1'b0}}, cfg.centering_even});
		x2_sq   = x2 * x2;
		y2_sq   = y2 * y2;
		edge_ok = EW'(x2) > EW'(cfg.edge_threshold);
	end

	always_comb begin
		rad_sq  = CMPW'(sq_x_s4) + CMPW'(sq_y_s4);
		ring_ok = (rad_sq > CMPW'(cfg.inner_radius_sq))
			&& (rad_sq < CMPW'(cfg.outer_radius_sq));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4) v_s4 <= up_valid;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && up_valid) begin
			ok_s4   <= up_ok && edge_ok;
			sq_x_s4 <= x2_sq[QW-1:0];
			sq_y_s4 <= y2_sq[QW-1:0];
		end
		if (rdy_s5 && v_s4) begin
			mask_s5 <= ok_s4 && ring_ok;
		end
	end

	assign out_valid = v_s5;
	assign mask_bit  = mask_s5;

	`AMRS_ASSERT_NEXT(a_reject_clears, v_s4 && !ok_s4 && rdy_s5, !mask_s5, "rejected pixel produced a set mask bit")

endmodule

### hw/rtl/annular_mask_rotate_shift_pixel_core.sv
// Annular mask rotate/shift pixel core: one mask bit per output pixel coordinate.
// Input channel in_valid/in_stall carries pixel_row and pixel_col; a beat is taken at
// a rising edge with in_valid high and in_stall low. Output channel out_valid/out_stall
// carries mask_bit, taken the same way.
// Each pixel is mapped back through the shift, then the rotation about the frame
// centre (rounding to nearest), and the source pixel is tested against the annulus
// and the edge threshold. Anything that leaves the frame gives a zero bit.
// Five register stages: shift, rotation products, rotation sum, squares, compare.
// An accepted beat moves through these stage registers in order to out_valid; one beat
// per cycle while out_stall stays low, fully pipelined multipliers (six per pixel).
// When out_stall is high, bubbles in the pipe still fill; in_stall rises only once
// every stage holds a beat. Nothing is dropped or repeated while stalled.
// Configuration writes (cfg_valid/cfg_ready, always ready) set the eight registers
// and should be made only while the pipe is empty.
// Reset (arst_n low) empties the pipe and loads the default register values.
// depends on amrs_pkg, amrs_cfg_regs, amrs_shift_rot, amrs_annulus
module annular_mask_rotate_shift_pixel_core #(
	parameter int IMAGE_SIZE = amrs_pkg::IMAGE_SIZE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [amrs_pkg::PIX_W-1:0]          pixel_row,
	input  logic [amrs_pkg::PIX_W-1:0]          pixel_col,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                mask_bit,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [amrs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [amrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW = $clog2(IMAGE_SIZE);

	amrs_pkg::cfg_t cfg;
	logic           in_ready;
	logic           rot_valid, rot_ready, rot_ok;
	logic [CW-1:0]  rot_row, rot_col;

	assign in_stall = !in_ready;

	amrs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	amrs_shift_rot #(
		.IMAGE_SIZE (IMAGE_SIZE)
	) u_shift_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.up_valid  (in_valid),
		.up_ready  (in_ready),
		.pixel_row (pixel_row),
		.pixel_col (pixel_col),
		.dn_valid  (rot_valid),
		.dn_ready  (rot_ready),
		.dn_ok     (rot_ok),
		.dn_row    (rot_row),
		.dn_col    (rot_col)
	);

	amrs_annulus #(
		.IMAGE_SIZE (IMAGE_SIZE)
	) u_annulus (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.up_valid  (rot_valid),
		.up_ready  (rot_ready),
		.up_ok     (rot_ok),
		.up_row    (rot_row),
		.up_col    (rot_col),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.mask_bit  (mask_bit)
	);

endmodule

### test/amrs_mask_checker.sv
// scoreboard for the annular mask rotate/shift pixel core: tracks register writes,
// predicts the mask bit of every accepted pixel beat and compares it with the output
// depends on amrs_pkg
module amrs_mask_checker
	import amrs_pkg::*;
#(
	parameter int IMAGE_SIZE = IMAGE_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [PIX_W-1:0]      pixel_row,
	input  logic [PIX_W-1:0]      pixel_col,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  mask_bit,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct {
		logic [PIX_W-1:0] row;
		logic [PIX_W-1:0] col;
		logic             mask;
	} mask_beat_t;

	mask_beat_t pending_masks[$];
	mask_beat_t beat;
	mask_beat_t oldest;

	logic        [RAD_W-1:0]   inner_lim;
	logic        [RAD_W-1:0]   outer_lim;
	logic signed [EDGE_W-1:0]  edge_lim;
	logic signed [TRIG_W-1:0]  cos_q;
	logic signed [TRIG_W-1:0]  sin_q;
	logic signed [SHIFT_W-1:0] row_shift_q;
	logic signed [SHIFT_W-1:0] col_shift_q;
	logic                      half_offset;

	function automatic logic in_frame(input longint r, input longint c);
		return r >= 0 && r < IMAGE_SIZE && c >= 0 && c < IMAGE_SIZE;
	endfunction

	// inverse shift, then inverse rotation about the frame centre, then annulus and edge test
	function automatic logic mask_for_pixel(input logic [PIX_W-1:0] row,
			input logic [PIX_W-1:0] col);
		longint sr, sc, o0, o1, a0, a1, rr, rc, x2, y2, rsq;
		if (!in_frame(longint'(row), longint'(col)))
			return 1'b0;
		sr = (longint'(row) * (1 << SHIFT_FRAC) - longint'(row_shift_q)
			+ (1 << (SHIFT_FRAC - 1))) >>> SHIFT_FRAC;
		sc = (longint'(col) * (1 << SHIFT_FRAC) - longint'(col_shift_q)
			+ (1 << (SHIFT_FRAC - 1))) >>> SHIFT_FRAC;
		if (!in_frame(sr, sc))
			return 1'b0;
		// doubled offsets from the centre, products land in 2^-17 pixel units
		o0 = 2 * sr - (IMAGE_SIZE - 1);
		o1 = 2 * sc - (IMAGE_SIZE - 1);
		a0 = longint'(cos_q) * o0 + longint'(sin_q) * o1
			+ longint'(IMAGE_SIZE) * (longint'(1) << TRIG_FRAC);
		a1 = -longint'(sin_q) * o0 + longint'(cos_q) * o1
			+ longint'(IMAGE_SIZE) * (longint'(1) << TRIG_FRAC);
		rr = a0 >>> (TRIG_FRAC + 1);
		rc = a1 >>> (TRIG_FRAC + 1);
		if (!in_frame(rr, rc))
			return 1'b0;
		x2 = 2 * rc - IMAGE_SIZE + longint'(half_offset);
		y2 = 2 * rr - IMAGE_SIZE + longint'(half_offset);
		rsq = x2 * x2 + y2 * y2;
		return rsq > longint'(inner_lim) && rsq < longint'(outer_lim)
			&& x2 > longint'(edge_lim);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_lim   = INNER_RST;
			outer_lim   = OUTER_RST;
			edge_lim    = EDGE_RST;
			cos_q       = COS_RST;
			sin_q       = SIN_RST;
			row_shift_q = SHIFT_RST;
			col_shift_q = SHIFT_RST;
			half_offset = CENTER_RST;
			pending_masks.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				beat.row  = pixel_row;
				beat.col  = pixel_col;
				beat.mask = mask_for_pixel(pixel_row, pixel_col);
				pending_masks.push_back(beat);
			end
			if (out_valid && !out_stall) begin
				if (pending_masks.size() == 0) begin
					$display("%0t: mask beat with nothing expected, got %0b", $time, mask_bit);
					mismatches <= mismatches + 1;
				end else begin
					oldest = pending_masks.pop_front();
					if (mask_bit !== oldest.mask) begin
						$display("%0t: mask_bit for pixel (%0d,%0d) expected %0b, got %0b",
							$time, oldest.row, oldest.col, oldest.mask, mask_bit);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_INNER:     inner_lim   = cfg_data[RAD_W-1:0];
					CFG_OUTER:     outer_lim   = cfg_data[RAD_W-1:0];
					CFG_EDGE:      edge_lim    = cfg_data[EDGE_W-1:0];
					CFG_COS:       cos_q       = cfg_data[TRIG_W-1:0];
					CFG_SIN:       sin_q       = cfg_data[TRIG_W-1:0];
					CFG_ROW_SHIFT: row_shift_q = cfg_data[SHIFT_W-1:0];
					CFG_COL_SHIFT: col_shift_q = cfg_data[SHIFT_W-1:0];
					CFG_CENTER:    half_offset = cfg_data[0];
					default: ;
				endcase
			end
			outstanding <= pending_masks.size();
		end
	end

endmodule

### test/tb_top.sv
// top of the annular mask rotate/shift pixel core testbench: clock, reset, pixel
// and register stimulus, output back-pressure and the verdict
// depends on amrs_pkg, amrs_mask_checker and annular_mask_rotate_shift_pixel_core
module tb_top;
	import amrs_pkg::*;

	localparam int IMAGE_SIZE  = IMAGE_SIZE_DEF;
	localparam int LATENCY     = 5;
	localparam int HOLD_CYCLES = 80;
	localparam int RAND_PHASES = 9;
	localparam int PHASE_BEATS = 100;
	localparam int CYCLE_LIMIT = 400000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [PIX_W-1:0]      pixel_row;
	logic [PIX_W-1:0]      pixel_col;
	logic                  out_valid;
	logic                  out_stall;
	logic                  mask_bit;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int  mismatches;
	int  outstanding;
	int  cycle_count;
	int  holds_asked;
	int  holds_done;
	int  stall_left;
	bit  calm;
	bit  raster;
	int  scan_row;
	int  scan_col;
	int  inner_v;
	real ang;

	annular_mask_rotate_shift_pixel_core #(.IMAGE_SIZE(IMAGE_SIZE)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_row (pixel_row),
		.pixel_col (pixel_col),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.mask_bit  (mask_bit),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	amrs_mask_checker #(.IMAGE_SIZE(IMAGE_SIZE)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_row   (pixel_row),
		.pixel_col   (pixel_col),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mask_bit    (mask_bit),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_len();
		int pick;
		if (calm)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_pixel(input int row, input int col);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		pixel_row <= row[PIX_W-1:0];
		pixel_col <= col[PIX_W-1:0];
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_regs(input int inner, input int outer, input int edge_lim,
			input int cos_v, input int sin_v, input int row_sh, input int col_sh,
			input int centre);
		write_reg(CFG_INNER, CFG_DATA_W'(inner));
		write_reg(CFG_OUTER, CFG_DATA_W'(outer));
		write_reg(CFG_EDGE, CFG_DATA_W'(edge_lim));
		write_reg(CFG_COS, CFG_DATA_W'(cos_v));
		write_reg(CFG_SIN, CFG_DATA_W'(sin_v));
		write_reg(CFG_ROW_SHIFT, CFG_DATA_W'(row_sh));
		write_reg(CFG_COL_SHIFT, CFG_DATA_W'(col_sh));
		write_reg(CFG_CENTER, CFG_DATA_W'(centre));
	endtask

	// stop offering and wait for the pipe to run dry
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
	endtask

	// output side back-pressure, plus long hold-offs on request
	initial begin
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (holds_done != holds_asked) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done = holds_done + 1;
			end else if (stall_left > 0) begin
				stall_left = stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				stall_left = idle_len();
				out_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left = stall_left - 1;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count = cycle_count + 1;
		end
		$display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
		$display("tb_top failed");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		pixel_row   = '0;
		pixel_col   = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		calm        = 1'b0;
		holds_asked = 0;
		holds_done  = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: identity mapping, full annulus
		send_pixel(0, 0);
		send_pixel(0, 255);
		send_pixel(255, 0);
		send_pixel(255, 255);
		send_pixel(128, 128);

		// quarter turn, one and a half pixel row shift sitting on a rounding tie
		settle();
		load_regs(1000, 60000, 0, 0, 65536, 384, -1280, 0);
		send_pixel(0, 0);
		send_pixel(255, 255);
		send_pixel(127, 128);
		send_pixel(128, 127);
		send_pixel(8'h55, 8'hAA);
		send_pixel(8'hAA, 8'h55);

		// half turn with full frame shifts and an edge threshold of 1024
		settle();
		load_regs(0, 1048575, 1024, -65536, 0, 65536, -65536, 1);
		send_pixel(255, 255);
		send_pixel(0, 0);
		send_pixel(128, 128);

		// register values past their nominal range, used as given
		settle();
		load_regs(1048575, 0, -2048, -131072, 131071, -131072, 131071, 1);
		send_pixel(0, 255);
		send_pixel(255, 0);
		send_pixel(64, 192);

		// eighth turn, small shifts on ties, outer limit between the corner radii
		settle();
		load_regs(0, 130051, -1, 46341, -46341, 128, -128, 0);
		send_pixel(0, 0);
		send_pixel(100, 200);
		send_pixel(200, 100);
		send_pixel(255, 0);

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			settle();
			ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
			inner_v = $urandom_range(0, 50000);
			load_regs(inner_v, inner_v + $urandom_range(0, 90000),
				$urandom_range(0, 2048) - 1024,
				int'(65536.0 * $cos(ang)), int'(65536.0 * $sin(ang)),
				$urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096,
				$urandom_range(0, 1));
			calm = (phase % 4 == 1);
			// keep offering while the output side holds off, so the pipe backs up
			if (phase == 2) begin
				calm = 1'b1;
				holds_asked = holds_asked + 1;
			end
			raster   = 1'($urandom_range(0, 1));
			scan_row = $urandom_range(0, IMAGE_SIZE - 1);
			scan_col = $urandom_range(0, IMAGE_SIZE - 1);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (raster && $urandom_range(0, 9) != 0) begin
					scan_col = scan_col + 1;
					if (scan_col == IMAGE_SIZE) begin
						scan_col = 0;
						scan_row = (scan_row + 1) % IMAGE_SIZE;
					end
				end else begin
					scan_row = $urandom_range(0, IMAGE_SIZE - 1);
					scan_col = $urandom_range(0, IMAGE_SIZE - 1);
				end
				send_pixel(scan_row, scan_col);
			end
		end

		calm = 1'b0;
		settle();
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_top passed");
		end else begin
			if (outstanding != 0)
				$display("%0t: %0d mask beats never arrived", $time, outstanding);
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
